/* hw/rtl/line_segment_clipper_defines.svh */
// Assertion macros used by the checker of the line segment clipper.
`ifndef LINE_SEGMENT_CLIPPER_DEFINES_SVH
`define LINE_SEGMENT_CLIPPER_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define LSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that cond in one cycle leads to prop in the next.
`define LSC_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) else $error(msg);

`endif

/* hw/rtl/lsc_pkg.sv */
package lsc_pkg;

	localparam int COORD_BITS = 16;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = 2 * DIFF_BITS;
	localparam int STEP_BITS  = 4;
	localparam logic [STEP_BITS-1:0] MAX_CLIP_STEPS = STEP_BITS'(8);

	localparam logic [3:0] OC_LEFT   = 4'd1;
	localparam logic [3:0] OC_RIGHT  = 4'd2;
	localparam logic [3:0] OC_BOTTOM = 4'd4;
	localparam logic [3:0] OC_TOP    = 4'd8;

	localparam logic [1:0] REG_LEFT   = 2'd0;
	localparam logic [1:0] REG_BOTTOM = 2'd1;
	localparam logic [1:0] REG_RIGHT  = 2'd2;
	localparam logic [1:0] REG_TOP    = 2'd3;

	localparam logic signed [COORD_BITS-1:0] RST_LEFT   = COORD_BITS'(100);
	localparam logic signed [COORD_BITS-1:0] RST_BOTTOM = COORD_BITS'(100);
	localparam logic signed [COORD_BITS-1:0] RST_RIGHT  = COORD_BITS'(300);
	localparam logic signed [COORD_BITS-1:0] RST_TOP    = COORD_BITS'(300);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_PREP,
		ST_MUL,
		ST_DIV,
		ST_WAIT,
		ST_UPD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic mul;
		logic upd;
		logic emit;
		logic accept;
	} dp_cmd_t;

	typedef struct packed {
		logic [3:0] code1;
		logic [3:0] code2;
		logic       out_busy;
	} dp_status_t;

endpackage

/* hw/rtl/lsc_div.sv */
module lsc_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [lsc_pkg::PROD_BITS-1:0]       dividend,
	input  logic [lsc_pkg::DIFF_BITS-1:0]       divisor,
	output logic                                done,
	output logic [lsc_pkg::PROD_BITS-1:0]       quotient
);

	localparam int CNT_BITS = $clog2(lsc_pkg::PROD_BITS + 1);

	logic [CNT_BITS-1:0]              cnt_q;
	logic                             busy_q;
	logic                             done_q;
	logic [lsc_pkg::DIFF_BITS:0]      rem_q;
	logic [lsc_pkg::PROD_BITS-1:0]    quo_q;
	logic [lsc_pkg::DIFF_BITS-1:0]    dvs_q;
	logic [lsc_pkg::DIFF_BITS:0]      rem_sh;
	logic [lsc_pkg::DIFF_BITS:0]      rem_sub;
	logic                             fits;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		rem_sh  = {rem_q[lsc_pkg::DIFF_BITS-1:0], quo_q[lsc_pkg::PROD_BITS-1]};
		rem_sub = rem_sh - {1'b0, dvs_q};
		fits    = (rem_sh >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(lsc_pkg::PROD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub : rem_sh;
			quo_q <= {quo_q[lsc_pkg::PROD_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* hw/rtl/lsc_dp.sv */
module lsc_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [lsc_pkg::COORD_BITS-1:0]      cfg_data,
	input  logic [4*lsc_pkg::COORD_BITS-1:0]    in_data,
	input  lsc_pkg::dp_cmd_t                    cmd,
	output lsc_pkg::dp_status_t                 status,
	output logic [lsc_pkg::PROD_BITS-1:0]       div_dividend,
	output logic [lsc_pkg::DIFF_BITS-1:0]       div_divisor,
	input  logic [lsc_pkg::PROD_BITS-1:0]       div_quotient,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                out_accepted,
	output logic [4*lsc_pkg::COORD_BITS-1:0]    out_data
);

	localparam int CB = lsc_pkg::COORD_BITS;
	localparam int DB = lsc_pkg::DIFF_BITS;

	logic signed [CB-1:0] win_left_q, win_bottom_q, win_right_q, win_top_q;
	logic signed [CB-1:0] x1_q, y1_q, x2_q, y2_q;
	logic signed [DB-1:0] a_q, b_q, d_q;
	logic                 axis_y_q, side1_q;
	logic signed [CB-1:0] edge_q;
	logic [lsc_pkg::PROD_BITS-1:0] prod_q;
	logic [DB-1:0]        dmag_q;
	logic                 neg_q, dzero_q;
	logic                 out_valid_q, out_acc_q;
	logic [4*CB-1:0]      out_data_q;

	logic [3:0]           code1, code2, oc;
	logic                 p_axis_y;
	logic signed [CB-1:0] p_edge;
	logic signed [DB-1:0] p_a, p_b, p_d;
	logic [DB-1:0]        mag_a, mag_b;
	logic signed [DB:0]   q_s, base_s, new_s;
	logic signed [CB-1:0] new_c;

	function automatic logic [3:0] outcode(input logic signed [CB-1:0] x,
		input logic signed [CB-1:0] y, input logic signed [CB-1:0] l,
		input logic signed [CB-1:0] b, input logic signed [CB-1:0] r,
		input logic signed [CB-1:0] t);
		logic [3:0] c;
		c = '0;
		if (x < l) c = c | lsc_pkg::OC_LEFT;
		if (x > r) c = c | lsc_pkg::OC_RIGHT;
		if (y < b) c = c | lsc_pkg::OC_BOTTOM;
		if (y > t) c = c | lsc_pkg::OC_TOP;
		return c;
	endfunction

	function automatic logic [DB-1:0] magn(input logic signed [DB-1:0] v);
		return v[DB-1] ? DB'(-v) : DB'(v);
	endfunction

	always_comb begin
		code1 = outcode(x1_q, y1_q, win_left_q, win_bottom_q, win_right_q, win_top_q);
		code2 = outcode(x2_q, y2_q, win_left_q, win_bottom_q, win_right_q, win_top_q);
		oc    = (code1 != 4'd0) ? code1 : code2;
		if ((oc & lsc_pkg::OC_TOP) != 4'd0) begin
			p_axis_y = 1'b1;
			p_edge   = win_top_q;
		end else if ((oc & lsc_pkg::OC_BOTTOM) != 4'd0) begin
			p_axis_y = 1'b1;
			p_edge   = win_bottom_q;
		end else if ((oc & lsc_pkg::OC_RIGHT) != 4'd0) begin
			p_axis_y = 1'b0;
			p_edge   = win_right_q;
		end else begin
			p_axis_y = 1'b0;
			p_edge   = win_left_q;
		end
		if (p_axis_y) begin
			p_a = DB'(x2_q) - DB'(x1_q);
			p_b = DB'(p_edge) - DB'(y1_q);
			p_d = DB'(y2_q) - DB'(y1_q);
		end else begin
			p_a = DB'(y2_q) - DB'(y1_q);
			p_b = DB'(p_edge) - DB'(x1_q);
			p_d = DB'(x2_q) - DB'(x1_q);
		end
		mag_a  = magn(a_q);
		mag_b  = magn(b_q);
		// quotient never exceeds |a|, so its low DB bits hold it
		q_s    = dzero_q ? '0 : (neg_q ? -$signed({1'b0, div_quotient[DB-1:0]})
			: $signed({1'b0, div_quotient[DB-1:0]}));
		base_s = axis_y_q ? (DB+1)'(x1_q) : (DB+1)'(y1_q);
		new_s  = base_s + q_s;
		new_c  = new_s[CB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q   <= lsc_pkg::RST_LEFT;
			win_bottom_q <= lsc_pkg::RST_BOTTOM;
			win_right_q  <= lsc_pkg::RST_RIGHT;
			win_top_q    <= lsc_pkg::RST_TOP;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					lsc_pkg::REG_LEFT:   win_left_q   <= cfg_data;
					lsc_pkg::REG_BOTTOM: win_bottom_q <= cfg_data;
					lsc_pkg::REG_RIGHT:  win_right_q  <= cfg_data;
					lsc_pkg::REG_TOP:    win_top_q    <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x1_q <= in_data[CB-1:0];
			y1_q <= in_data[2*CB-1:CB];
			x2_q <= in_data[3*CB-1:2*CB];
			y2_q <= in_data[4*CB-1:3*CB];
		end else if (cmd.upd) begin
			if (side1_q) begin
				x1_q <= axis_y_q ? new_c : edge_q;
				y1_q <= axis_y_q ? edge_q : new_c;
			end else begin
				x2_q <= axis_y_q ? new_c : edge_q;
				y2_q <= axis_y_q ? edge_q : new_c;
			end
		end
		if (cmd.prep) begin
			a_q      <= p_a;
			b_q      <= p_b;
			d_q      <= p_d;
			axis_y_q <= p_axis_y;
			edge_q   <= p_edge;
			side1_q  <= (code1 != 4'd0);
		end
		if (cmd.mul) begin
			prod_q  <= lsc_pkg::PROD_BITS'(mag_a * mag_b);
			dmag_q  <= magn(d_q);
			neg_q   <= (a_q[DB-1] ^ b_q[DB-1]) ^ d_q[DB-1];
			dzero_q <= (d_q == '0);
		end
		if (cmd.emit) begin
			out_acc_q  <= cmd.accept;
			out_data_q <= cmd.accept ? {y2_q, x2_q, y1_q, x1_q} : '0;
		end
	end

	assign status.code1    = code1;
	assign status.code2    = code2;
	assign status.out_busy = out_valid_q && !out_ready;
	assign div_dividend    = prod_q;
	assign div_divisor     = dmag_q;
	assign out_valid       = out_valid_q;
	assign out_accepted    = out_acc_q;
	assign out_data        = out_data_q;

endmodule

/* hw/rtl/lsc_ctrl.sv */
module lsc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lsc_pkg::dp_status_t  status,
	input  logic                 div_done,
	output logic                 div_start,
	output lsc_pkg::dp_cmd_t     cmd
);

	lsc_pkg::state_t                   state_q, state_d;
	logic [lsc_pkg::STEP_BITS-1:0]     steps_q, steps_d;
	logic                              acc_q, acc_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsc_pkg::ST_IDLE;
			steps_q <= '0;
			acc_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			steps_q <= steps_d;
			acc_q   <= acc_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		steps_d   = steps_q;
		acc_d     = acc_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		cmd       = '0;
		unique case (state_q)
			lsc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					steps_d  = '0;
					state_d  = lsc_pkg::ST_EVAL;
				end
			end
			lsc_pkg::ST_EVAL: begin
				if ((status.code1 | status.code2) == 4'd0) begin
					acc_d   = 1'b1;
					state_d = lsc_pkg::ST_EMIT;
				end else if ((status.code1 & status.code2) != 4'd0
					|| steps_q >= lsc_pkg::MAX_CLIP_STEPS) begin
					acc_d   = 1'b0;
					state_d = lsc_pkg::ST_EMIT;
				end else begin
					steps_d = steps_q + lsc_pkg::STEP_BITS'(1);
					state_d = lsc_pkg::ST_PREP;
				end
			end
			lsc_pkg::ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = lsc_pkg::ST_MUL;
			end
			lsc_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = lsc_pkg::ST_DIV;
			end
			lsc_pkg::ST_DIV: begin
				div_start = 1'b1;
				state_d   = lsc_pkg::ST_WAIT;
			end
			lsc_pkg::ST_WAIT: begin
				if (div_done) state_d = lsc_pkg::ST_UPD;
			end
			lsc_pkg::ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = lsc_pkg::ST_EVAL;
			end
			lsc_pkg::ST_EMIT: begin
				if (!status.out_busy) begin
					cmd.emit   = 1'b1;
					cmd.accept = acc_q;
					state_d    = lsc_pkg::ST_IDLE;
				end
			end
			default: state_d = lsc_pkg::ST_IDLE;
		endcase
	end

endmodule

/* hw/rtl/line_segment_clipper.sv */
// Channel   Dir  Signals                          Contents
// s_axis    in   s_tvalid s_tready s_tdata[63:0]  one segment: start and end point
// m_axis    out  m_tvalid m_tready m_tdata[63:0]  clipped segment, accept flag in tuser
// cfg       in   cfg_we cfg_index cfg_data        window edges: left, bottom, right, top
//
// One segment at a time. Each segment is taken, gets a final outcode test and is emitted;
// before that, each clip step runs outcode test, prep, multiply, divider start, a wait on
// the 34-bit restoring divider and update; a regular window needs at most four steps,
// and the eight-step bound caps any other case.
// The divider produces one quotient bit per cycle.
// The result register frees the input side: a new segment is taken while the last result
// still waits for m_tready; a finished segment holds in its emit state until the slot clears.
// arst_n clears the control and loads the window with its default 100..300 square.
module line_segment_clipper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// start_x [15:0], start_y [31:16], end_x [47:32], end_y [63:48]
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// clip_start_x [15:0], clip_start_y [31:16], clip_end_x [47:32], clip_end_y [63:48]
	output logic [63:0] m_tdata,
	// accepted [0]
	output logic        m_tuser,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	lsc_pkg::dp_cmd_t               cmd;
	lsc_pkg::dp_status_t            status;
	logic                           div_start;
	logic                           div_done;
	logic [lsc_pkg::PROD_BITS-1:0]  div_dividend;
	logic [lsc_pkg::DIFF_BITS-1:0]  div_divisor;
	logic [lsc_pkg::PROD_BITS-1:0]  div_quotient;

	// sequencer: outcode tests, step count, handshake
	lsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.status    (status),
		.div_done  (div_done),
		.div_start (div_start),
		.cmd       (cmd)
	);

	// endpoints, window registers, multiplier and result register
	lsc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_data      (s_tdata),
		.cmd          (cmd),
		.status       (status),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_quotient (div_quotient),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_accepted (m_tuser),
		.out_data     (m_tdata)
	);

	// magnitude divider, one bit per cycle
	lsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

endmodule

/* hw/rtl/lsc_checker.sv */
`include "line_segment_clipper_defines.svh"

module lsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tuser
);

	// a stalled result holds
	`LSC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tuser, m_tdata}), "stall lost")
	// rejected segments carry zero coordinates
	`LSC_ASSERT(a_reject_zero, (m_tvalid && !m_tuser) |-> (m_tdata == 64'd0), "reject not zero")
	// a taken segment closes the input until it is processed
	`LSC_ASSERT_NEXT(a_one_at_time, s_tvalid && s_tready, !s_tready, "second segment taken")
	// no result appears in the cycle right after a segment is taken
	`LSC_ASSERT_NEXT(a_no_instant, s_tvalid && s_tready && !m_tvalid, !m_tvalid, "early result")

endmodule

bind line_segment_clipper lsc_checker u_lsc_checker (.*);

/* tb/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// One segment's start and end point, all signed coordinates.
	typedef struct {
		logic signed [15:0] x1, y1, x2, y2;
	} segment_t;

	typedef struct {
		logic               accepted;
		logic signed [15:0] x1, y1, x2, y2;
	} clip_t;

	// Clip model plus the queue of clipped segments still owed by the block.
	class clip_scoreboard;
		longint win_left, win_bottom, win_right, win_top;
		clip_t  pending[$];
		int     errors;

		function new();
			win_left = 100; win_bottom = 100; win_right = 300; win_top = 300;
			errors = 0;
		endfunction

		function void set_edge(logic [1:0] idx, logic signed [15:0] v);
			case (idx)
				lsc_pkg::REG_LEFT: begin
					win_left = v;
				end
				lsc_pkg::REG_BOTTOM: begin
					win_bottom = v;
				end
				lsc_pkg::REG_RIGHT: begin
					win_right = v;
				end
				default: begin
					win_top = v;
				end
			endcase
		endfunction

		function logic [3:0] region(longint x, longint y);
			logic [3:0] c;
			c = 4'd0;
			if (x < win_left) c |= lsc_pkg::OC_LEFT;
			if (x > win_right) c |= lsc_pkg::OC_RIGHT;
			if (y < win_bottom) c |= lsc_pkg::OC_BOTTOM;
			if (y > win_top) c |= lsc_pkg::OC_TOP;
			return c;
		endfunction

		// Truncating a*b/d on magnitudes, sign applied afterwards.
		function longint interp(longint a, longint b, longint d);
			longint q;
			bit     neg;
			if (d == 0) return 0;
			neg = ((a < 0) != (b < 0)) != (d < 0);
			q = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) / (d < 0 ? -d : d);
			return neg ? -q : q;
		endfunction

		function void note_segment(segment_t s);
			longint     x1, y1, x2, y2, nx, ny;
			logic [3:0] c1, c2, oc;
			int         steps;
			clip_t      r;
			x1 = s.x1; y1 = s.y1; x2 = s.x2; y2 = s.y2;
			c1 = region(x1, y1);
			c2 = region(x2, y2);
			steps = 0;
			r = '{default: '0};
			forever begin
				if ((c1 | c2) == 0) begin
					r = '{1'b1, x1[15:0], y1[15:0], x2[15:0], y2[15:0]};
					break;
				end
				if ((c1 & c2) != 0 || steps >= lsc_pkg::MAX_CLIP_STEPS) break;
				steps++;
				oc = (c1 != 0) ? c1 : c2;
				if (oc & lsc_pkg::OC_TOP) begin
					nx = x1 + interp(x2 - x1, win_top - y1, y2 - y1);
					ny = win_top;
				end else if (oc & lsc_pkg::OC_BOTTOM) begin
					nx = x1 + interp(x2 - x1, win_bottom - y1, y2 - y1);
					ny = win_bottom;
				end else if (oc & lsc_pkg::OC_RIGHT) begin
					ny = y1 + interp(y2 - y1, win_right - x1, x2 - x1);
					nx = win_right;
				end else begin
					ny = y1 + interp(y2 - y1, win_left - x1, x2 - x1);
					nx = win_left;
				end
				if (c1 != 0) begin
					x1 = nx; y1 = ny; c1 = region(x1, y1);
				end else begin
					x2 = nx; y2 = ny; c2 = region(x2, y2);
				end
			end
			pending.push_back(r);
		endfunction

		function void check_result(clip_t got);
			clip_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result acc=%0b (%0d,%0d)-(%0d,%0d)", $time,
					got.accepted, got.x1, got.y1, got.x2, got.y2);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.accepted !== want.accepted) begin
				$display("%0t: accepted expected %0b actual %0b", $time, want.accepted,
					got.accepted);
				errors++;
			end
			if (got.x1 !== want.x1) begin
				$display("%0t: clip_start_x expected %0d actual %0d", $time, want.x1, got.x1);
				errors++;
			end
			if (got.y1 !== want.y1) begin
				$display("%0t: clip_start_y expected %0d actual %0d", $time, want.y1, got.y1);
				errors++;
			end
			if (got.x2 !== want.x2) begin
				$display("%0t: clip_end_x expected %0d actual %0d", $time, want.x2, got.x2);
				errors++;
			end
			if (got.y2 !== want.y2) begin
				$display("%0t: clip_end_y expected %0d actual %0d", $time, want.y2, got.y2);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = lsc_pkg::REG_LEFT;
	logic [15:0] cfg_data = '0;

	clip_scoreboard sb = new();
	// Idle percentage per side; zero gives the stretch with no gaps.
	int          send_idle = 37;
	int          recv_idle = 37;
	bit          hold_recv = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	line_segment_clipper u_top (.*);

	// Receiver: sample transfers at the rising edge, change tready at the falling one.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result('{m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
				m_tdata[63:48]});
	end

	always @(negedge clk) begin
		m_tready <= !hold_recv && ($urandom_range(99) >= recv_idle);
	end

	// Long hold-off on the output so the result slot fills and s_tready drops.
	task automatic stall_receiver(int cycles);
		hold_recv = 1'b1;
		repeat (cycles) @(negedge clk);
		hold_recv = 1'b0;
	endtask

	// Offer one segment, with random gaps before it; the model sees it on transfer.
	// tvalid stays high after the transfer until the next gap or the next drain.
	task automatic send_segment(segment_t s);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {s.y2, s.x2, s.y1, s.x1};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_segment(s);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_edge(logic [1:0] idx, logic signed [15:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(negedge clk);
		sb.set_edge(idx, v);
	endtask

	task automatic set_window(logic signed [15:0] l, b, r, t);
		write_edge(lsc_pkg::REG_LEFT, l);
		write_edge(lsc_pkg::REG_BOTTOM, b);
		write_edge(lsc_pkg::REG_RIGHT, r);
		write_edge(lsc_pkg::REG_TOP, t);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [15:0] rand_coord();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2, 3: return 16'($urandom);
			default: return $signed(16'($urandom_range(600))) - 16'sd100;
		endcase
	endfunction

	task automatic send_random(int count);
		segment_t s;
		repeat (count) begin
			s = '{rand_coord(), rand_coord(), rand_coord(), rand_coord()};
			send_segment(s);
		end
	endtask

	initial begin
		segment_t directed[$];
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Default window 100..300: inside, trivial reject, each edge crossed,
		// both ends outside, extremes, and a vertical and horizontal line.
		directed = '{
			'{16'sd150, 16'sd150, 16'sd250, 16'sd250},
			'{16'sd0, 16'sd0, 16'sd50, 16'sd50},
			'{16'sd200, 16'sd200, 16'sd200, 16'sd400},
			'{16'sd200, 16'sd200, 16'sd200, -16'sd50},
			'{16'sd200, 16'sd200, 16'sd500, 16'sd210},
			'{16'sd200, 16'sd200, 16'sd0, 16'sd190},
			'{16'sd0, 16'sd0, 16'sd400, 16'sd400},
			'{16'sd0, 16'sd350, 16'sd350, 16'sd0},
			'{16'sd0, 16'sd300, 16'sd50, 16'sd400},
			'{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff},
			'{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff},
			'{16'sd100, 16'sd100, 16'sd300, 16'sd300},
			'{16'sh8000, 16'sd200, 16'sh7fff, 16'sd200},
			'{16'sd0, 16'sd250, 16'sd120, 16'sh7fff}
		};
		foreach (directed[i]) send_segment(directed[i]);
		wait_drained();

		// Extreme window, then an inverted one.
		set_window(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
		send_segment('{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
		send_random(100);
		wait_drained();
		set_window(16'sd50, 16'sd50, -16'sd50, -16'sd50);
		send_segment('{-16'sd100, 16'sd0, 16'sd100, 16'sd0});
		send_random(100);
		wait_drained();

		// Degenerate single-point window; sender pauses below until drained.
		set_window(16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_random(100);
		wait_drained();

		// Random windows of modest size, with one run without idling and one
		// long output hold-off while the sender keeps offering.
		for (int ph = 0; ph < 10; ph++) begin
			logic signed [15:0] l, b;
			l = $signed(16'($urandom_range(300))) - 16'sd100;
			b = $signed(16'($urandom_range(300))) - 16'sd100;
			set_window(l, b, l + 16'($urandom_range(250)), b + 16'($urandom_range(250)));
			if (ph == 3) begin
				send_idle = 0; recv_idle = 0;
			end else begin
				send_idle = 37; recv_idle = 37;
			end
			if (ph == 5) begin
				fork
					stall_receiver(3000);
					send_random(40);
				join
			end
			send_random(100);
			wait_drained();
		end
		set_window(16'sd100, 16'sd100, 16'sd300, 16'sd300);

		wait_drained();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
